[rtl/mwo_pkg.sv]
// ----------------------------------------------------------------------------
// Multiwave phase oscillator package
// Shared widths, codes, command and configuration types, and the quarter-wave
// sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SAMPLE_BITS     = 16;
    localparam int SINE_TABLE_BITS = 10;

    localparam int QTAB_N      = 2 ** SINE_TABLE_BITS;
    localparam int FULL_SCALE  = 2 ** (SAMPLE_BITS - 1);
    localparam int OUT_MAX     = FULL_SCALE - 1;
    localparam int OUT_MIN     = -FULL_SCALE;
    localparam int ROUND_BIAS  = FULL_SCALE / 2;
    localparam int OUT_SHIFT   = SAMPLE_BITS - 1;

    localparam int WAVEFORM_W  = 2;
    localparam int FREQ_W      = 23;
    localparam int AMP_W       = 16;
    localparam int PS_W        = 34;
    localparam int CFG_DATA_W  = 34;
    localparam int CFG_INDEX_W = 3;
    localparam int FREQ_MAX    = 2 ** FREQ_W - 1;

    localparam int DEV_SHIFT   = 15;
    localparam int FSUM_W      = FREQ_W + 4;
    localparam int PS_SPLIT    = 17;
    localparam int MUL_A_W     = FREQ_W + 1;
    localparam int MUL_B_W     = PS_SPLIT + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int LO_W        = FREQ_W + PS_SPLIT;
    localparam int INC_FULL_W  = FREQ_W + PS_W;
    localparam int INC_SHIFT   = 48 - PHASE_BITS;
    localparam int WAVE_W      = SAMPLE_BITS + 1;
    localparam int TRI_W       = SAMPLE_BITS + 3;
    localparam int ACC_W       = PROD_W - OUT_SHIFT + 1;

    localparam logic [WAVEFORM_W-1:0] WAVEFORM_RESET  = '0;
    localparam logic [FREQ_W-1:0]     BASE_FREQ_RESET = FREQ_W'(112640);
    localparam logic [AMP_W-1:0]      AMP_RESET       = AMP_W'(32768);
    localparam logic [FREQ_W-1:0]     DEPTH_RESET     = '0;
    localparam logic [PS_W-1:0]       PS_RESET        = PS_W'(22906492);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef enum logic [WAVEFORM_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVEFORM    = 3'd0,
        CFG_BASE_FREQ   = 3'd1,
        CFG_AMPLITUDE   = 3'd2,
        CFG_MOD_DEPTH   = 3'd3,
        CFG_PHASE_SCALE = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEV,
        ST_WAVE,
        ST_INC_LO,
        ST_INC_HI,
        ST_ADV
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_DEV,
        MUL_WAVE,
        MUL_INC_LO,
        MUL_INC_HI
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     freq_en;
        logic     sample_en;
        logic     lo_en;
        logic     commit;
    } dp_cmd_t;

    typedef struct packed {
        wave_t             waveform;
        logic [FREQ_W-1:0] base_frequency;
        logic [AMP_W-1:0]  amplitude;
        logic [FREQ_W-1:0] mod_depth;
        logic [PS_W-1:0]   phase_scale;
    } cfg_t;

    // The entries next to a quarter cycle round up to full scale, so the
    // table carries one bit above the sample width.
    typedef logic [WAVE_W-1:0] qtab_t [QTAB_N];

    function automatic qtab_t build_qtab();
        qtab_t       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      sum;
        for (int k = 0; k < QTAB_N; k++) begin
            x   = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2  = (x * x) >> 30;
            t   = x;
            sum = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                t = ((t * x2) >> 30) / TAYLOR_DIV[n-1];
                if ((n % 2) == 1) begin
                    sum = sum - longint'(t);
                end
                else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = WAVE_W'((64'(sum) * 64'(FULL_SCALE) + 64'(2 ** 29)) >> 30);
        end
        return tab;
    endfunction

    localparam qtab_t SINE_TAB = build_qtab();

endpackage

[rtl/mwo_in_if.sv]
// ----------------------------------------------------------------------------
// Oscillator input channel
// Valid/ready channel carrying one audio frame tick per transaction.
// ----------------------------------------------------------------------------
interface mwo_in_if;
    import mwo_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mod_sample;
    logic signed [SAMPLE_BITS-1:0] mix_sample;

    modport source (output valid, output mod_sample, output mix_sample, input ready);
    modport sink   (input valid, input mod_sample, input mix_sample, output ready);
endinterface

[rtl/mwo_out_if.sv]
// ----------------------------------------------------------------------------
// Oscillator output channel
// Valid/ready channel carrying one output sample per transaction.
// ----------------------------------------------------------------------------
interface mwo_out_if;
    import mwo_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          wrapped;

    modport source (output valid, output sample, output wrapped, input ready);
    modport sink   (input valid, input sample, input wrapped, output ready);
endinterface

[rtl/mwo_cfg.sv]
// ----------------------------------------------------------------------------
// Oscillator configuration registers
// Write-only register bank; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module mwo_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mwo_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mwo_pkg::cfg_t                      cfg
);
    import mwo_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WAVEFORM:    cfg_next.waveform       = wave_t'(cfg_data[WAVEFORM_W-1:0]);
                CFG_BASE_FREQ:   cfg_next.base_frequency = cfg_data[FREQ_W-1:0];
                CFG_AMPLITUDE:   cfg_next.amplitude      = cfg_data[AMP_W-1:0];
                CFG_MOD_DEPTH:   cfg_next.mod_depth      = cfg_data[FREQ_W-1:0];
                CFG_PHASE_SCALE: cfg_next.phase_scale    = cfg_data[PS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.waveform       <= wave_t'(WAVEFORM_RESET);
            cfg_reg.base_frequency <= BASE_FREQ_RESET;
            cfg_reg.amplitude      <= AMP_RESET;
            cfg_reg.mod_depth      <= DEPTH_RESET;
            cfg_reg.phase_scale    <= PS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

[rtl/mwo_ctrl.sv]
// ----------------------------------------------------------------------------
// Oscillator controller
// Sequences the shared multiplier through the steps of one tick and owns the
// handshakes on both channels.
// ----------------------------------------------------------------------------
module mwo_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output mwo_pkg::dp_cmd_t cmd
);
    import mwo_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_ADV) && out_free);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV:    state_next = ST_WAVE;
            ST_WAVE:   state_next = ST_INC_LO;
            ST_INC_LO: state_next = ST_INC_HI;
            ST_INC_HI: state_next = ST_ADV;
            ST_ADV:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_DEV : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = MUL_DEV;
        cmd.capture   = accept;
        case (state_reg)
            ST_DEV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEV;
            end
            ST_WAVE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WAVE;
                cmd.freq_en = 1'b1;
            end
            ST_INC_LO:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_INC_LO;
                cmd.sample_en = 1'b1;
            end
            ST_INC_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INC_HI;
                cmd.lo_en   = 1'b1;
            end
            ST_ADV:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                cmd.commit = 1'b0;
            end
        endcase
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

[rtl/mwo_dp.sv]
// ----------------------------------------------------------------------------
// Oscillator datapath
// Phase accumulator, waveform generation with a registered sine ROM, one
// shared 24 x 18 multiplier and the output register.
// ----------------------------------------------------------------------------
module mwo_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mwo_pkg::dp_cmd_t                    cmd,
    input  mwo_pkg::cfg_t                       cfg,
    input  logic signed [mwo_pkg::SAMPLE_BITS-1:0] mod_sample,
    input  logic signed [mwo_pkg::SAMPLE_BITS-1:0] mix_sample,
    output logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                wrapped
);
    import mwo_pkg::*;

    localparam logic signed [WAVE_W-1:0] FS_W = WAVE_W'(FULL_SCALE);

    logic signed [SAMPLE_BITS-1:0]     mod_reg;
    logic signed [SAMPLE_BITS-1:0]     mix_reg;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [PROD_W-1:0]          prod_next;
    logic [FREQ_W-1:0]                 freq_reg;
    logic [FREQ_W-1:0]                 freq_next;
    logic signed [SAMPLE_BITS-1:0]     sample_reg;
    logic signed [SAMPLE_BITS-1:0]     sample_next;
    logic [LO_W-1:0]                   lo_reg;
    logic [PHASE_BITS-1:0]             phase_reg;
    logic [PHASE_BITS-1:0]             phase_next;
    logic [WAVE_W-1:0]                 rom_q_reg;
    logic signed [SAMPLE_BITS-1:0]     out_sample_reg;
    logic                              out_wrapped_reg;

    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;

    logic [SINE_TABLE_BITS+1:0]        sine_top;
    logic [1:0]                        quad;
    logic [SINE_TABLE_BITS-1:0]        idx;
    logic [SINE_TABLE_BITS-1:0]        rom_addr;
    logic signed [WAVE_W-1:0]          sine_mag;
    logic signed [WAVE_W-1:0]          sine_val;
    logic signed [WAVE_W-1:0]          square_val;
    logic signed [WAVE_W-1:0]          saw_val;
    logic signed [TRI_W-1:0]           tri_t;
    logic signed [TRI_W-1:0]           tri_full;
    logic signed [WAVE_W-1:0]          wave;

    logic signed [PROD_W-1:0]          dev_full;
    logic signed [FSUM_W-1:0]          freq_sum;
    logic signed [PROD_W-1:0]          round_full;
    logic signed [ACC_W-1:0]           acc;
    logic [INC_FULL_W-1:0]             inc_full;
    logic [PHASE_BITS-1:0]             inc;
    logic [PHASE_BITS:0]               phase_sum;

    // Waveform at the current phase.
    assign sine_top = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
    assign quad     = sine_top[SINE_TABLE_BITS +: 2];
    assign idx      = sine_top[SINE_TABLE_BITS-1:0];
    assign rom_addr = quad[0] ? (SINE_TABLE_BITS'(0) - idx) : idx;

    // In the falling quadrants an index of zero points one past the table and reads full scale.
    assign sine_mag   = (quad[0] && (idx == '0)) ? FS_W : signed'(rom_q_reg);
    assign sine_val   = quad[1] ? -sine_mag : sine_mag;
    assign square_val = phase_reg[PHASE_BITS-1] ? -FS_W : FS_W;
    assign saw_val    = signed'({1'b0, phase_reg[PHASE_BITS-1 -: SAMPLE_BITS]}) - FS_W;
    assign tri_t      = signed'(TRI_W'(phase_reg[PHASE_BITS-1 -: SAMPLE_BITS+1]));
    assign tri_full   = phase_reg[PHASE_BITS-1] ? (TRI_W'(3 * FULL_SCALE) - tri_t)
                                                : (tri_t - TRI_W'(FULL_SCALE));

    always_comb
    begin
        case (cfg.waveform)
            WAVE_SINE:     wave = sine_val;
            WAVE_SQUARE:   wave = square_val;
            WAVE_SAW:      wave = saw_val;
            WAVE_TRIANGLE: wave = WAVE_W'(tri_full);
            default:       wave = sine_val;
        endcase
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DEV:
            begin
                mul_a = signed'({1'b0, cfg.mod_depth});
                mul_b = MUL_B_W'(mod_reg);
            end
            MUL_WAVE:
            begin
                mul_a = signed'(MUL_A_W'(cfg.amplitude));
                mul_b = MUL_B_W'(wave);
            end
            MUL_INC_LO:
            begin
                mul_a = signed'({1'b0, freq_reg});
                mul_b = signed'({1'b0, cfg.phase_scale[PS_SPLIT-1:0]});
            end
            MUL_INC_HI:
            begin
                mul_a = signed'({1'b0, freq_reg});
                mul_b = signed'({1'b0, cfg.phase_scale[PS_W-1:PS_SPLIT]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Instantaneous frequency, clamped to the register range.
    assign dev_full = prod_reg >>> DEV_SHIFT;
    assign freq_sum = signed'(FSUM_W'(cfg.base_frequency)) + FSUM_W'(dev_full);

    always_comb
    begin
        if (freq_sum < 0)
        begin
            freq_next = '0;
        end
        else if (freq_sum > FSUM_W'(FREQ_MAX))
        begin
            freq_next = FREQ_W'(FREQ_MAX);
        end
        else
        begin
            freq_next = freq_sum[FREQ_W-1:0];
        end
    end

    // Gain, rounding, mixing and saturation.
    assign round_full = (prod_reg + PROD_W'(ROUND_BIAS)) >>> OUT_SHIFT;
    assign acc        = ACC_W'(round_full) + ACC_W'(mix_reg);

    always_comb
    begin
        if (acc > ACC_W'(OUT_MAX))
        begin
            sample_next = SAMPLE_BITS'(OUT_MAX);
        end
        else if (acc < ACC_W'(OUT_MIN))
        begin
            sample_next = SAMPLE_BITS'(OUT_MIN);
        end
        else
        begin
            sample_next = acc[SAMPLE_BITS-1:0];
        end
    end

    // Phase increment from the two partial products, then the phase advance.
    assign inc_full   = {prod_reg[LO_W-1:0], PS_SPLIT'(0)} + INC_FULL_W'(lo_reg);
    assign inc        = inc_full[INC_SHIFT +: PHASE_BITS];
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, inc};
    assign phase_next = cmd.commit ? phase_sum[PHASE_BITS-1:0] : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_TAB[rom_addr];
        if (cmd.capture)
        begin
            mod_reg <= mod_sample;
            mix_reg <= mix_sample;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.freq_en)
        begin
            freq_reg <= freq_next;
        end
        if (cmd.sample_en)
        begin
            sample_reg <= sample_next;
        end
        if (cmd.lo_en)
        begin
            lo_reg <= prod_reg[LO_W-1:0];
        end
        if (cmd.commit)
        begin
            out_sample_reg  <= sample_reg;
            out_wrapped_reg <= phase_sum[PHASE_BITS];
        end
    end

    assign sample  = out_sample_reg;
    assign wrapped = out_wrapped_reg;
endmodule

[rtl/multiwave_phase_oscillator.sv]
// ----------------------------------------------------------------------------
// Multiwave phase oscillator
// Numerically controlled oscillator with sine, square, saw and triangle
// outputs, frequency modulation and an upstream mix input.
// ----------------------------------------------------------------------------
// Each input transaction on in_stream is one audio frame tick carrying a
// modulation sample and an upstream audio sample. Each tick yields exactly
// one output transaction on out_stream: the oscillator output scaled by the
// amplitude, summed with the upstream sample and saturated, together with a
// flag that marks a phase wrap.
// The configuration port is written with cfg_we, cfg_index and cfg_data and
// should only be written while no tick is in flight.
// A tick runs from acceptance to the result appearing in the output register
// through four passes of the single shared 24 x 18 multiplier
// (deviation, gain, and the two halves of the phase increment) and one phase
// advance step. A new tick is accepted in that final step when the output
// register is free; no tick is accepted during the multiplier steps.
// Reset restores the register defaults, clears the phase to zero and leaves
// no output pending. When the receiver stalls, the result stays in the
// output register; the next tick completes its work and then waits in its
// final step, with the phase held, until the output register is free.
// ----------------------------------------------------------------------------
module multiwave_phase_oscillator (
    input  logic                            clk,
    input  logic                            rst_n,
    mwo_in_if.sink                          in_stream,
    mwo_out_if.source                       out_stream,
    input  logic                            cfg_we,
    input  logic [mwo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mwo_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;

    mwo_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mwo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_stream.valid),
        .in_ready  (in_stream.ready),
        .out_valid (out_stream.valid),
        .out_ready (out_stream.ready),
        .cmd       (cmd)
    );

    mwo_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .mod_sample (in_stream.mod_sample),
        .mix_sample (in_stream.mix_sample),
        .sample     (out_stream.sample),
        .wrapped    (out_stream.wrapped)
    );
endmodule

[rtl/mwo_checker.sv]
// ----------------------------------------------------------------------------
// Multiwave phase oscillator checker
// Port-level assertions on handshake behaviour and tick timing.
// ----------------------------------------------------------------------------
module mwo_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample,
    input logic                                wrapped
);
    import mwo_pkg::*;

    logic in_accept;

    assign in_accept = in_valid && in_ready;

    // A stalled result must stay offered.
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("Output valid dropped while stalled.");

    a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(sample) && $stable(wrapped)))
        else $error("Output payload changed while stalled.");

    // The multiplier steps of a tick leave no room for another transaction.
    a_in_spacing : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("Input accepted while a tick was still in progress.");

    // A fresh result is loaded in the final step of the tick that produced it.
    a_out_latency : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_accept, 6))
        else $error("Output appeared without a matching input transaction.");
endmodule

bind multiwave_phase_oscillator mwo_checker u_mwo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .sample    (out_stream.sample),
    .wrapped   (out_stream.wrapped)
);
